>>> rtl/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared constants and types for the fixed-length frame deframer.
// ----------------------------------------------------------------------------
package ffd_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int ID_POS      = 3;
  localparam int ID_LEN      = 4;
  localparam int DATA_POS    = 7;
  localparam int DATA_LEN    = 8;
  localparam int CNT_W       = 32;

  localparam logic [7:0] HEADER_RESET  = 8'hAA;
  localparam logic [7:0] TRAILER_RESET = 8'h55;

  typedef logic [7:0] byte_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_HEADER  = 1'b0,
    REG_TRAILER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                    window_flushed;
    logic                    resync_error;
    logic                    frame_ready;
    logic [CNT_W-1:0]        frame_total;
    logic [CNT_W-1:0]        error_total;
    logic [8*DATA_LEN-1:0]   payload;
    logic [8*ID_LEN-1:0]     can_id;
  } ffd_result_t;

endpackage

>>> rtl/ffd_window.sv
// ----------------------------------------------------------------------------
// ffd_window
// Byte window, header search, realignment and frame/error counters.
// ----------------------------------------------------------------------------
module ffd_window (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  ffd_pkg::byte_t       rx_byte,
  input  ffd_pkg::byte_t       header_value,
  input  ffd_pkg::byte_t       trailer_value,
  output ffd_pkg::ffd_result_t result
);

  ffd_pkg::byte_t                  win_r   [ffd_pkg::FRAME_BYTES];
  ffd_pkg::byte_t                  win_nxt [ffd_pkg::FRAME_BYTES];
  ffd_pkg::byte_t                  w_cur   [ffd_pkg::FRAME_BYTES];
  logic [ffd_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic [ffd_pkg::CNT_W-1:0]       err_cnt_r, err_cnt_nxt;
  logic [ffd_pkg::CNT_W-1:0]       frm_cnt_r, frm_cnt_nxt;
  logic [ffd_pkg::FRAME_BYTES-1:0] hit;
  logic [ffd_pkg::POS_W-1:0]       pos;
  logic [ffd_pkg::POS_W-1:0]       sh;
  logic [ffd_pkg::POS_W:0]         j;
  logic                            full, any_hit, do_shift;

  // window as it stands with this byte appended
  always_comb begin
    for (int i = 0; i < ffd_pkg::FRAME_BYTES; i++) begin
      w_cur[i] = (fill_r == ffd_pkg::FILL_W'(i)) ? rx_byte : win_r[i];
      hit[i]   = (w_cur[i] == header_value);
    end
  end

  assign full    = (fill_r == ffd_pkg::FILL_W'(ffd_pkg::FRAME_BYTES - 1));
  assign any_hit = |hit;

  // first header position, lowest index wins
  always_comb begin
    pos = '0;
    for (int i = ffd_pkg::FRAME_BYTES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pos = ffd_pkg::POS_W'(i);
      end
    end
  end

  always_comb begin
    result      = '0;
    fill_nxt    = fill_r + 1'b1;
    err_cnt_nxt = err_cnt_r;
    frm_cnt_nxt = frm_cnt_r;
    do_shift    = 1'b0;
    sh          = (pos != '0) ? pos : ffd_pkg::POS_W'(1);
    if (full) begin
      if (!any_hit) begin
        fill_nxt              = '0;
        result.window_flushed = 1'b1;
      end else if (pos != '0 || w_cur[ffd_pkg::FRAME_BYTES-1] != trailer_value) begin
        // drop up to the header, or one byte on a bad trailer
        do_shift            = 1'b1;
        fill_nxt            = ffd_pkg::FILL_W'(ffd_pkg::FRAME_BYTES) - ffd_pkg::FILL_W'(sh);
        err_cnt_nxt         = err_cnt_r + 1'b1;
        result.resync_error = 1'b1;
      end else begin
        fill_nxt           = '0;
        frm_cnt_nxt        = frm_cnt_r + 1'b1;
        result.frame_ready = 1'b1;
        for (int k = 0; k < ffd_pkg::ID_LEN; k++) begin
          if (ffd_pkg::ID_POS + k < ffd_pkg::FRAME_BYTES - 1) begin
            result.can_id[8*k +: 8] = w_cur[ffd_pkg::ID_POS + k];
          end
        end
        for (int k = 0; k < ffd_pkg::DATA_LEN; k++) begin
          if (ffd_pkg::DATA_POS + k < ffd_pkg::FRAME_BYTES - 1) begin
            result.payload[8*k +: 8] = w_cur[ffd_pkg::DATA_POS + k];
          end
        end
      end
    end
    result.error_total = err_cnt_nxt;
    result.frame_total = frm_cnt_nxt;
  end

  // realign: move bytes down by the drop count
  always_comb begin
    j = '0;
    for (int i = 0; i < ffd_pkg::FRAME_BYTES; i++) begin
      win_nxt[i] = w_cur[i];
      j = (ffd_pkg::POS_W + 1)'(i) + {1'b0, sh};
      if (do_shift && j < (ffd_pkg::POS_W + 1)'(ffd_pkg::FRAME_BYTES)) begin
        win_nxt[i] = w_cur[j[ffd_pkg::POS_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      err_cnt_r <= '0;
      frm_cnt_r <= '0;
    end else if (step) begin
      fill_r    <= fill_nxt;
      err_cnt_r <= err_cnt_nxt;
      frm_cnt_r <= frm_cnt_nxt;
    end
  end

  a_fill_below_frame: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < ffd_pkg::FILL_W'(ffd_pkg::FRAME_BYTES))
    else $error("window fill reached frame length");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> $onehot0({result.frame_ready, result.resync_error, result.window_flushed}))
    else $error("more than one outcome for one byte");

  a_partial_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !full) |-> (!result.frame_ready && !result.resync_error &&
                         !result.window_flushed))
    else $error("outcome flagged before window was full");

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (result.frame_ready || result.window_flushed)) |=> fill_r == '0)
    else $error("window not cleared after frame or flush");

endmodule

>>> rtl/fixed_frame_deframer_16byte.sv
// ----------------------------------------------------------------------------
// fixed_frame_deframer_16byte
// Fixed-length 16-byte frame sync for a USB-to-CAN serial byte stream.
// ----------------------------------------------------------------------------
// Accepts one received byte per beat and returns exactly one result beat per
// byte. Bytes collect in a 16-byte window; once it is full it is checked:
// no header byte flushes it, a header off position 0 drops the bytes before
// it and counts a resync error, a bad trailer drops one byte and counts an
// error, and a good frame yields the little-endian CAN id (bytes 3..6) and
// eight payload bytes (7..14). One byte per clock while out_tready holds;
// bytes pass an input and a result register, bounded by the window update
// loop (append, header search, realign). The user must write header and
// trailer values through the cfg port only while idle; the block does not enforce it.
module fixed_frame_deframer_16byte (
  input  logic         clk,
  input  logic         rst_n,
  // input byte stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] rx_byte
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,   // [31:0] can_id, [95:32] payload,
                                    // [127:96] error_total, [159:128] frame_total
  output logic [2:0]   out_tuser,   // [0] frame_ready, [1] resync_error,
                                    // [2] window_flushed
  // configuration writes
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [7:0]   cfg_wdata
);

  ffd_pkg::byte_t      header_r, trailer_r;
  logic                in_valid_r;
  ffd_pkg::byte_t      in_byte_r;
  logic                out_valid_r;
  ffd_pkg::ffd_result_t res, res_r;
  logic                adv, step;

  // Configuration registers; both indexes are defined.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= ffd_pkg::HEADER_RESET;
      trailer_r <= ffd_pkg::TRAILER_RESET;
    end else if (cfg_we) begin
      unique case (ffd_pkg::cfg_reg_t'(cfg_addr))
        ffd_pkg::REG_HEADER:  header_r  <= cfg_wdata;
        ffd_pkg::REG_TRAILER: trailer_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the result register when it is empty or being drained; the
  // input register refills in the same cycle it hands its byte on.
  assign adv       = !out_valid_r || out_tready;
  assign step      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  ffd_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .rx_byte       (in_byte_r),
    .header_value  (header_r),
    .trailer_value (trailer_r),
    .result        (res)
  );

  // Result register: load on step, drop the valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.frame_total, res_r.error_total, res_r.payload, res_r.can_id};
  assign out_tuser  = {res_r.window_flushed, res_r.resync_error, res_r.frame_ready};

endmodule

>>> tb/fixed_frame_deframer_16byte_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_frame_deframer_16byte_tb
// Self-checking bench for the 16-byte header/trailer frame sync.
// ----------------------------------------------------------------------------
// Feeds raw link bytes into the deframer and checks every result beat against
// a bit-accurate window model kept in the bench. Directed frames cover a good
// frame, a bad trailer, a misplaced header and a header-free window, then the
// header and trailer registers are swept through their extremes. Random
// traffic mixes good frames with random content, broken frames and line noise
// under several idle/stall mixes, and one phase holds off the result side
// long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module fixed_frame_deframer_16byte_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_we;
  logic [0:0]   cfg_addr;
  logic [7:0]   cfg_wdata;

  fixed_frame_deframer_16byte uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Window model: shadow registers, byte window and running counters
  // --------------------------------------------------------------------------
  ffd_pkg::byte_t            hdr_val;
  ffd_pkg::byte_t            trl_val;
  ffd_pkg::byte_t            win [ffd_pkg::FRAME_BYTES];
  int                        win_fill;
  logic [ffd_pkg::CNT_W-1:0] err_cnt;
  logic [ffd_pkg::CNT_W-1:0] frm_cnt;

  // expected beats in send order; written by the sender, read by the checker
  ffd_pkg::ffd_result_t want_buf [4096];
  int want_wr = 0;
  int want_rd = 0;

  int send_idle_pct;     // chance in 100 that the sender skips a cycle
  int stall_pct;         // chance in 100 that the receiver drops tready
  int hold_reqs  = 0;    // long hold-offs asked for by the tests
  int hold_taken = 0;    // hold-offs already started by the receiver
  int hold_left  = 0;    // cycles the receiver still holds off completely
  int bytes_sent;
  int beats_seen = 0;
  int mismatches = 0;

  // Append one byte and evaluate the window once it is full.
  function automatic ffd_pkg::ffd_result_t deframe_byte(ffd_pkg::byte_t rx);
    ffd_pkg::ffd_result_t r;
    int          hpos;
    int          drop_n;
    int          k;
    r      = '0;
    drop_n = 0;
    win[win_fill] = rx;
    win_fill++;
    if (win_fill == ffd_pkg::FRAME_BYTES) begin
      // first header wins: scan from the top so the lowest match sticks
      hpos = ffd_pkg::FRAME_BYTES;
      for (k = ffd_pkg::FRAME_BYTES - 1; k >= 0; k--) begin
        if (win[k] == hdr_val) hpos = k;
      end
      if (hpos == ffd_pkg::FRAME_BYTES) begin
        drop_n           = ffd_pkg::FRAME_BYTES;
        r.window_flushed = 1'b1;
      end else if (hpos > 0) begin
        drop_n         = hpos;
        err_cnt++;
        r.resync_error = 1'b1;
      end else if (win[ffd_pkg::FRAME_BYTES-1] != trl_val) begin
        drop_n         = 1;
        err_cnt++;
        r.resync_error = 1'b1;
      end else begin
        for (k = 0; k < ffd_pkg::ID_LEN; k++)
          r.can_id[8*k +: 8] = win[ffd_pkg::ID_POS+k];
        for (k = 0; k < ffd_pkg::DATA_LEN; k++)
          r.payload[8*k +: 8] = win[ffd_pkg::DATA_POS+k];
        drop_n        = ffd_pkg::FRAME_BYTES;
        frm_cnt++;
        r.frame_ready = 1'b1;
      end
      // shift the surviving bytes down to position 0
      for (k = 0; k < ffd_pkg::FRAME_BYTES - drop_n; k++) win[k] = win[k+drop_n];
      win_fill = ffd_pkg::FRAME_BYTES - drop_n;
    end
    r.error_total = err_cnt;
    r.frame_total = frm_cnt;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: tready pattern and beat checking
  // --------------------------------------------------------------------------
  // Drive tready at the falling edge; a long hold-off overrides the random mix.
  always @(negedge clk) begin
    if (hold_reqs != hold_taken) begin
      hold_taken = hold_reqs;
      hold_left  = 300;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH beat %0d %s: got %0h want %0h", beats_seen, what, got, want);
  endtask

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    ffd_pkg::ffd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (want_rd == want_wr) begin
        report_mismatch("unexpected beat", out_tdata[63:0], 64'd0);
      end else begin
        want = want_buf[want_rd % 4096];
        want_rd++;
        if (out_tuser[0] !== want.frame_ready)
          report_mismatch("frame_ready", out_tuser[0], want.frame_ready);
        if (out_tuser[1] !== want.resync_error)
          report_mismatch("resync_error", out_tuser[1], want.resync_error);
        if (out_tuser[2] !== want.window_flushed)
          report_mismatch("window_flushed", out_tuser[2], want.window_flushed);
        if (out_tdata[31:0] !== want.can_id)
          report_mismatch("can_id", out_tdata[31:0], want.can_id);
        if (out_tdata[95:32] !== want.payload)
          report_mismatch("payload", out_tdata[95:32], want.payload);
        if (out_tdata[127:96] !== want.error_total)
          report_mismatch("error_total", out_tdata[127:96], want.error_total);
        if (out_tdata[159:128] !== want.frame_total)
          report_mismatch("frame_total", out_tdata[159:128], want.frame_total);
      end
      beats_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Input side helpers
  // --------------------------------------------------------------------------
  // Queue the expected beat for one accepted byte.
  task automatic store_expected(ffd_pkg::ffd_result_t r);
    want_buf[want_wr % 4096] = r;
    want_wr++;
  endtask

  // Offer one byte from a falling edge; hold it until the handshake completes.
  task automatic send_byte(ffd_pkg::byte_t rx);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    store_expected(deframe_byte(rx));
    bytes_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Header, command, format, id and payload random, trailer; cut at len bytes.
  task automatic send_frame(ffd_pkg::byte_t hdr, ffd_pkg::byte_t trl, int len);
    ffd_pkg::byte_t frm [ffd_pkg::FRAME_BYTES];
    int    k;
    frm[0] = hdr;
    for (k = 1; k < ffd_pkg::FRAME_BYTES - 1; k++)
      frm[k] = ffd_pkg::byte_t'($urandom_range(255));
    frm[ffd_pkg::FRAME_BYTES-1] = trl;
    for (k = 0; k < len; k++) send_byte(frm[k]);
  endtask

  // Wait until every result has come back, plus the pipeline depth.
  task automatic wait_idle();
    while (want_rd != want_wr) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register from a falling edge; the block must be idle.
  task automatic write_reg(ffd_pkg::cfg_reg_t idx, ffd_pkg::byte_t val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    unique case (idx)
      ffd_pkg::REG_HEADER:  hdr_val = val;
      ffd_pkg::REG_TRAILER: trl_val = val;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset header/trailer: good frame, bad trailer, header-free window,
  // misplaced header, then a frame completed after the realign.
  task automatic test_reset_values();
    ffd_pkg::byte_t good [ffd_pkg::FRAME_BYTES] = '{ffd_pkg::HEADER_RESET, 8'h00, 8'hFF,
                                  8'h01, 8'h80, 8'hFF, 8'h00,
                                  8'hFF, 8'h00, 8'h7F, 8'h80,
                                  8'h01, 8'hFE, 8'h55, 8'hAA,
                                  ffd_pkg::TRAILER_RESET};
    int k;
    send_idle_pct = 0;
    stall_pct     = 0;
    for (k = 0; k < ffd_pkg::FRAME_BYTES; k++) send_byte(good[k]);
    // bad trailer: drop one byte, the remaining 15 hold no header
    send_byte(ffd_pkg::HEADER_RESET);
    for (k = 1; k < ffd_pkg::FRAME_BYTES - 1; k++) send_byte(ffd_pkg::byte_t'(8'h10 + k));
    send_byte(8'h00);
    // sixteenth byte fills a header-free window: flush
    send_byte(8'hFF);
    // three noise bytes ahead of a header: drop them and count one error
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_frame(ffd_pkg::HEADER_RESET, ffd_pkg::TRAILER_RESET, ffd_pkg::FRAME_BYTES);
    wait_idle();
  endtask

  // Sweep both registers through their extremes, equal values included.
  task automatic test_register_sweep();
    ffd_pkg::byte_t hdrs [4] = '{8'h00, 8'hFF, 8'h5A, ffd_pkg::HEADER_RESET};
    ffd_pkg::byte_t trls [4] = '{8'hFF, 8'h00, 8'h5A, ffd_pkg::TRAILER_RESET};
    int k;
    for (k = 0; k < 4; k++) begin
      write_reg(ffd_pkg::REG_HEADER, hdrs[k]);
      write_reg(ffd_pkg::REG_TRAILER, trls[k]);
      send_frame(hdr_val, trl_val, ffd_pkg::FRAME_BYTES);
      wait_idle();
    end
  endtask

  // Mostly good frames with random content; the rest broken frames and noise.
  task automatic test_random_traffic(int n_bytes, int idle, int stall);
    int    start;
    int    pick;
    int    k;
    ffd_pkg::byte_t bad_trl;
    write_reg(ffd_pkg::REG_HEADER, ffd_pkg::byte_t'($urandom_range(255)));
    write_reg(ffd_pkg::REG_TRAILER, ffd_pkg::byte_t'($urandom_range(255)));
    send_idle_pct = idle;
    stall_pct     = stall;
    start         = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(hdr_val, trl_val, ffd_pkg::FRAME_BYTES);
      end else if (pick < 80) begin
        do bad_trl = ffd_pkg::byte_t'($urandom_range(255)); while (bad_trl == trl_val);
        send_frame(hdr_val, bad_trl, ffd_pkg::FRAME_BYTES);
      end else if (pick < 88) begin
        send_frame(hdr_val, trl_val, $urandom_range(1, ffd_pkg::FRAME_BYTES - 1));
      end else begin
        for (k = $urandom_range(1, 8); k > 0; k--)
          send_byte(ffd_pkg::byte_t'($urandom_range(255)));
      end
    end
    wait_idle();
  endtask

  // Hold off the result side while the sender keeps offering bytes.
  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs++;
    for (k = 0; k < 4; k++) send_frame(hdr_val, trl_val, ffd_pkg::FRAME_BYTES);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    cfg_we        = 1'b0;
    cfg_addr      = ffd_pkg::REG_HEADER;
    cfg_wdata     = 8'h00;
    hdr_val       = ffd_pkg::HEADER_RESET;
    trl_val       = ffd_pkg::TRAILER_RESET;
    win_fill      = 0;
    err_cnt       = '0;
    frm_cnt       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_values();
    test_register_sweep();
    test_random_traffic(380, 0, 0);
    test_random_traffic(380, 81, 0);
    test_random_traffic(380, 0, 81);
    test_random_traffic(380, 14, 14);
    test_backpressure();

    repeat (10) @(negedge clk);
    if (mismatches == 0 && want_rd == want_wr) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/ffd_pkg.sv
rtl/ffd_window.sv
rtl/fixed_frame_deframer_16byte.sv
tb/fixed_frame_deframer_16byte_tb.sv
